>>> rtl/core/bencode_list_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef BENCODE_LIST_TOKENIZER_UNIT_DEFINES_SVH
`define BENCODE_LIST_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define BLTOK_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define BLTOK_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLTOK_CHECK(label, prop, msg)
`define BLTOK_CHECK_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/core/bltok_pkg.sv
// Types and constants for the bencode list tokenizer.
// No dependencies; imported by bltok_core and the top level.
`timescale 1ns / 1ps

package bltok_pkg;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_TOKEN = 3'd1,
    PH_INT   = 3'd2,
    PH_LEN   = 3'd3,
    PH_STR   = 3'd4,
    PH_IDLE  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_OPEN  = 3'd1,
    EV_CLOSE = 3'd2,
    EV_INT   = 3'd3,
    EV_STR   = 3'd4,
    EV_BYTE  = 3'd5,
    EV_STOP  = 3'd6
  } event_t;

  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Largest magnitudes for positive and negative number text.
  localparam logic [35:0] LIM_POS = 36'h07FFFFFFF;
  localparam logic [35:0] LIM_NEG = 36'h080000000;

  typedef struct packed {
    event_t             kind;
    logic signed [31:0] value;
    logic [7:0]         sbyte;
    logic [4:0]         depth;
    logic               bad;
  } result_t;

endpackage

>>> rtl/core/bltok_core.sv
// Parser state and per-byte event logic of the bencode list tokenizer.
// Depends on bltok_pkg and bencode_list_tokenizer_unit_defines.svh.
`timescale 1ns / 1ps
`include "bencode_list_tokenizer_unit_defines.svh"

module bltok_core
  import bltok_pkg::*;
#(
  parameter int MAX_DEPTH = 16,
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       end_of_data,
  output result_t    res
);

  phase_t               phase, phase_next;
  logic [DEPTH_W-1:0]   depth, depth_next;
  logic [31:0]          acc, acc_next;
  logic                 neg, neg_next;
  logic                 bad, bad_next;
  logic                 seen_char, seen_char_next;
  logic                 seen_digit, seen_digit_next;
  logic [30:0]          rem, rem_next;

  logic                 is_digit;
  logic                 is_sign;
  logic [35:0]          acc_x10;
  logic [35:0]          acc_sum;
  logic [35:0]          limit;
  logic                 over;
  logic                 num_bad;
  logic [31:0]          int_val;
  logic [31:0]          len_val;
  logic                 at_max;
  logic [DEPTH_W-1:0]   depth_dec;
  logic [30:0]          rem_dec;
  logic [DEPTH_W+4:0]   depth_ext;

  assign is_digit  = in_byte inside {[CH_ZERO:CH_NINE]};
  assign is_sign   = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
  assign acc_x10   = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
  assign acc_sum   = acc_x10 + {32'd0, in_byte[3:0]};
  assign limit     = neg ? LIM_NEG : LIM_POS;
  assign over      = acc_sum > limit;
  assign num_bad   = bad || !seen_digit;
  assign int_val   = num_bad ? 32'd0 : (neg ? 32'd0 - acc : acc);
  assign len_val   = bad ? 32'd0 : acc;
  assign at_max    = depth >= DEPTH_W'(MAX_DEPTH);
  assign depth_dec = (depth != '0) ? depth - DEPTH_W'(1) : '0;
  assign rem_dec   = (rem != '0) ? rem - 31'd1 : '0;
  assign depth_ext = {5'd0, depth_next};

  // next state
  always_comb begin
    phase_next      = phase;
    depth_next      = depth;
    acc_next        = acc;
    neg_next        = neg;
    bad_next        = bad;
    seen_char_next  = seen_char;
    seen_digit_next = seen_digit;
    rem_next        = rem;
    if (phase != PH_IDLE) begin
      if (end_of_data) begin
        phase_next      = PH_IDLE;
        depth_next      = '0;
        rem_next        = '0;
        acc_next        = '0;
        neg_next        = 1'b0;
        bad_next        = 1'b0;
        seen_char_next  = 1'b0;
        seen_digit_next = 1'b0;
      end else begin
        case (phase)
          PH_WAIT: begin
            if (in_byte == CH_L) begin
              depth_next = DEPTH_W'(1);
              phase_next = PH_TOKEN;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_TOKEN: begin
            if (in_byte == CH_E) begin
              depth_next = depth_dec;
              if (depth_dec == '0) begin
                phase_next = PH_IDLE;
              end
            end else if (in_byte == CH_L) begin
              if (at_max) begin
                phase_next = PH_IDLE;
                depth_next = '0;
              end else begin
                depth_next = depth + DEPTH_W'(1);
              end
            end else if (in_byte == CH_I) begin
              acc_next        = '0;
              neg_next        = 1'b0;
              bad_next        = 1'b0;
              seen_char_next  = 1'b0;
              seen_digit_next = 1'b0;
              phase_next      = PH_INT;
            end else if (is_digit) begin
              acc_next        = {28'd0, in_byte[3:0]};
              neg_next        = 1'b0;
              bad_next        = 1'b0;
              seen_char_next  = 1'b0;
              seen_digit_next = 1'b1;
              phase_next      = PH_LEN;
            end else begin
              phase_next = PH_IDLE;
              depth_next = '0;
            end
          end
          PH_INT: begin
            if (in_byte == CH_E) begin
              acc_next        = '0;
              neg_next        = 1'b0;
              bad_next        = 1'b0;
              seen_char_next  = 1'b0;
              seen_digit_next = 1'b0;
              phase_next      = PH_TOKEN;
            end else begin
              seen_char_next = 1'b1;
              if (!seen_char && is_sign) begin
                neg_next = (in_byte == CH_MINUS);
              end else if (is_digit) begin
                seen_digit_next = 1'b1;
                if (!bad) begin
                  if (over) begin
                    bad_next = 1'b1;
                    acc_next = '0;
                  end else begin
                    acc_next = acc_sum[31:0];
                  end
                end
              end else begin
                bad_next = 1'b1;
                acc_next = '0;
              end
            end
          end
          PH_LEN: begin
            if (in_byte == CH_COLON) begin
              acc_next        = '0;
              neg_next        = 1'b0;
              bad_next        = 1'b0;
              seen_char_next  = 1'b0;
              seen_digit_next = 1'b0;
              rem_next        = len_val[30:0];
              phase_next      = (len_val != 32'd0) ? PH_STR : PH_TOKEN;
            end else if (is_digit) begin
              seen_digit_next = 1'b1;
              if (!bad) begin
                if (over) begin
                  bad_next = 1'b1;
                  acc_next = '0;
                end else begin
                  acc_next = acc_sum[31:0];
                end
              end
            end else begin
              bad_next = 1'b1;
              acc_next = '0;
            end
          end
          PH_STR: begin
            rem_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = PH_TOKEN;
            end
          end
          default: begin
            phase_next      = PH_IDLE;
            depth_next      = '0;
            rem_next        = '0;
            acc_next        = '0;
            neg_next        = 1'b0;
            bad_next        = 1'b0;
            seen_char_next  = 1'b0;
            seen_digit_next = 1'b0;
          end
        endcase
      end
    end
  end

  // event for the current byte
  always_comb begin
    res.kind  = EV_NONE;
    res.value = '0;
    res.sbyte = '0;
    res.depth = depth_ext[4:0];
    res.bad   = 1'b0;
    if (phase != PH_IDLE) begin
      if (end_of_data) begin
        res.kind = EV_STOP;
      end else begin
        case (phase)
          PH_WAIT: begin
            res.kind = (in_byte == CH_L) ? EV_OPEN : EV_STOP;
          end
          PH_TOKEN: begin
            if (in_byte == CH_E) begin
              res.kind = EV_CLOSE;
            end else if (in_byte == CH_L) begin
              res.kind = at_max ? EV_STOP : EV_OPEN;
            end else if (in_byte == CH_I || is_digit) begin
              res.kind = EV_NONE;
            end else begin
              res.kind = EV_STOP;
            end
          end
          PH_INT: begin
            if (in_byte == CH_E) begin
              res.kind  = EV_INT;
              res.value = $signed(int_val);
              res.bad   = num_bad;
            end
          end
          PH_LEN: begin
            if (in_byte == CH_COLON) begin
              res.kind  = EV_STR;
              res.value = $signed(len_val);
              res.bad   = bad;
            end
          end
          PH_STR: begin
            res.kind  = EV_BYTE;
            res.sbyte = in_byte;
          end
          default: begin
            res.kind = EV_NONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      depth      <= '0;
      acc        <= '0;
      neg        <= 1'b0;
      bad        <= 1'b0;
      seen_char  <= 1'b0;
      seen_digit <= 1'b0;
      rem        <= '0;
    end else if (step) begin
      phase      <= phase_next;
      depth      <= depth_next;
      acc        <= acc_next;
      neg        <= neg_next;
      bad        <= bad_next;
      seen_char  <= seen_char_next;
      seen_digit <= seen_digit_next;
      rem        <= rem_next;
    end
  end

  `BLTOK_CHECK(idle_no_depth, phase == PH_IDLE |-> depth == '0, "idle with lists open")
  `BLTOK_CHECK(str_has_bytes, phase == PH_STR |-> rem != '0, "string phase with no bytes left")
  `BLTOK_CHECK(len_not_negative, phase == PH_LEN |-> !neg, "sign set on a string length")
  `BLTOK_CHECK(depth_in_range, depth <= DEPTH_W'(MAX_DEPTH), "nesting beyond limit")

endmodule

>>> rtl/core/bencode_list_tokenizer_unit.sv
// Top level of the bencode list tokenizer: input register, parser, result register.
// Depends on bltok_pkg, bltok_core and bencode_list_tokenizer_unit_defines.svh.
//
//   channel  handshake                 payload
//   byte     byte_valid / byte_stall   in_byte, end_of_data
//   event    event_valid / event_stall event_kind, number_value, string_byte,
//                                      nesting_depth, malformed
//
// One byte per cycle unless event_stall holds; event_valid registers with the result.
// The parser state updates as a byte moves from the input register to the result register.
// Reset clears the handshake and parser state; the parser waits for the opening 'l'.
// A held event stalls the parser; byte_stall rises only when both registers are full.
`timescale 1ns / 1ps
`include "bencode_list_tokenizer_unit_defines.svh"

module bencode_list_tokenizer_unit
  import bltok_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         in_byte,
  input  logic               end_of_data,
  output logic               event_valid,
  input  logic               event_stall,
  output logic [2:0]         event_kind,
  output logic signed [31:0] number_value,
  output logic [7:0]         string_byte,
  output logic [4:0]         nesting_depth,
  output logic               malformed
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_eod;
  logic       advance;
  result_t    res;

  assign advance    = held_valid && (!event_valid || !event_stall);
  assign byte_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      held_byte <= in_byte;
      held_eod  <= end_of_data;
    end
  end

  bltok_core #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .in_byte    (held_byte),
    .end_of_data(held_eod),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_kind    <= res.kind;
      number_value  <= res.value;
      string_byte   <= res.sbyte;
      nesting_depth <= res.depth;
      malformed     <= res.bad;
    end
  end

  `BLTOK_CHECK(advance_fills_out, advance |=> event_valid, "transaction lost between stages")
  `BLTOK_CHECK(stop_clears_depth, event_valid && event_kind == EV_STOP |-> nesting_depth == 5'd0, "stop with lists open")
  `BLTOK_CHECK(bad_forces_zero, event_valid && malformed |-> number_value == 32'sd0, "malformed number with value")
  `BLTOK_CHECK(byte_only_in_string, event_valid && event_kind != EV_BYTE |-> string_byte == 8'd0, "string byte outside string")
  `BLTOK_CHECK_ALWAYS(stall_needs_item, byte_stall |-> held_valid, "stall with empty input register")

endmodule
